FILE: design/srb_pkg.sv
`timescale 1ns / 1ps
package srb_pkg;

	localparam int SEQ_W = 14;
	localparam int TAG_W = 16;
	localparam int LEN_W = 11;
	localparam int WIN_W = 13;

	localparam int MAX_PAYLOAD = 2045;

	localparam logic [1:0] REG_WINDOW = 2'd0;

	localparam logic [1:0] OP_ARRIVE  = 2'd0;
	localparam logic [1:0] OP_TX      = 2'd1;
	localparam logic [1:0] OP_DELIVER = 2'd2;

	localparam logic [1:0] PT_UNREL = 2'd0;
	localparam logic [1:0] PT_REL   = 2'd1;
	localparam logic [1:0] PT_ACK   = 2'd2;

	localparam logic [3:0] K_ACK_OK    = 4'd0;
	localparam logic [3:0] K_QUEUED    = 4'd1;
	localparam logic [3:0] K_STALE     = 4'd2;
	localparam logic [3:0] K_DUP       = 4'd3;
	localparam logic [3:0] K_STRAY     = 4'd4;
	localparam logic [3:0] K_SHORT     = 4'd5;
	localparam logic [3:0] K_FULL      = 4'd6;
	localparam logic [3:0] K_TX        = 4'd7;
	localparam logic [3:0] K_DELIVERED = 4'd8;
	localparam logic [3:0] K_GAP       = 4'd9;
	localparam logic [3:0] K_FREED     = 4'd10;
	localparam logic [3:0] K_NONE      = 4'd11;

	typedef struct packed {
		logic [1:0]       operation;
		logic [1:0]       pkt_type;
		logic [SEQ_W-1:0] pkt_seq;
		logic [LEN_W-1:0] frame_len;
		logic [TAG_W-1:0] buf_tag;
		logic [LEN_W-1:0] capacity;
	} req_t;

	typedef struct packed {
		logic [3:0]       out_kind;
		logic [SEQ_W-1:0] out_seq;
		logic [TAG_W-1:0] out_tag;
		logic [LEN_W-1:0] out_length;
		logic             send_ack;
		logic [15:0]      header_word;
		logic             last;
	} rsp_t;

	// Signed serial distance a - b in 14 bits.
	function automatic logic signed [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
		input logic [SEQ_W-1:0] b);
		seq_dist = signed'(a - b);
	endfunction

endpackage

FILE: design/srb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface srb_req_if;
	logic          valid;
	logic          ready;
	srb_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface srb_rsp_if;
	logic          valid;
	logic          ready;
	srb_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/sequence_reorder_buffer_unit.sv
// Steps: an arrive walks the queue from its tail (S_RD, S_CMP), then moves each displaced
// entry (S_SHRD, S_SHWR). A deliver frees each stale head, up to QUEUE_DEPTH of them, and
// shifts the entries behind it up (S_POP, S_SHWR), then scans the entries (S_HEAD, S_HEADC,
// S_OUT). A stalled result holds the scan in S_HEAD, but the shifts go on meanwhile.
// Throughput: one transaction at a time; the next is accepted after its last result leaves.
// Reset: arst_n clears count, send and expect sequences and sets the window to 3, not the queue.
`timescale 1ns / 1ps
`default_nettype none
module sequence_reorder_buffer_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	srb_req_if.sink          req,
	srb_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = srb_pkg::SEQ_W;
	localparam int EW = SW + 1 + srb_pkg::LEN_W + srb_pkg::TAG_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010,
		S_CMP   = 10'b0000000100,
		S_DECI  = 10'b0000001000,
		S_SHRD  = 10'b0000010000,
		S_SHWR  = 10'b0000100000,
		S_HEAD  = 10'b0001000000,
		S_HEADC = 10'b0010000000,
		S_POP   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} st_t;

	typedef struct packed {
		logic [SW-1:0]             seq;
		logic                      rel;
		logic [srb_pkg::LEN_W-1:0] len;
		logic [srb_pkg::TAG_W-1:0] tag;
	} ent_t;

	st_t st_q;
	srb_pkg::req_t r_q;
	logic [CW-1:0] cnt_q, idx_q, pos_q;
	logic [SW-1:0] send_q, exp_q;
	logic [12:0] win_q;
	logic found_q, dup_q, pop_mode_q, after_q;
	logic [CW-1:0] nfree_q;
	ent_t mem_q [QUEUE_DEPTH];
	ent_t rd_q, hold_q;
	logic [IW-1:0] ra, wa;
	logic we;
	ent_t wd;
	srb_pkg::rsp_t out_q;
	logic out_v_q;

	assign pready = 1'b1;
	assign prdata = {19'd0, win_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 13'd3;
		end else if (psel && penable && pwrite && paddr == srb_pkg::REG_WINDOW) begin
			win_q <= pwdata[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra];
	end

	assign req.ready = (st_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	logic signed [SW-1:0] d_new, d_head;
	logic [srb_pkg::LEN_W-1:0] clip;
	assign d_new = srb_pkg::seq_dist(r_q.pkt_seq, rd_q.seq);
	assign d_head = srb_pkg::seq_dist(rd_q.seq, exp_q);
	assign clip = (rd_q.len > r_q.capacity) ? r_q.capacity : rd_q.len;

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = hold_q;
		unique case (st_q)
			S_RD:   ra = IW'(idx_q - 1'b1);
			S_SHRD: ra = IW'(idx_q - 1'b1);
			S_HEAD: ra = IW'(idx_q);
			S_POP:  ra = IW'(idx_q);
			default: ra = '0;
		endcase
		if (st_q == S_SHWR) begin
			we = 1'b1;
			if (pop_mode_q) begin
				wa = IW'(idx_q - 1'b1);
				wd = rd_q;
			end else if (idx_q == pos_q) begin
				wa = IW'(pos_q);
				wd = hold_q;
			end else begin
				wa = IW'(idx_q);
				wd = rd_q;
			end
		end
	end

	function automatic srb_pkg::rsp_t mk(input logic [3:0] k, input logic [SW-1:0] s,
		input logic [15:0] t, input logic [10:0] l, input logic a, input logic [15:0] h,
		input logic lst);
		srb_pkg::rsp_t o;
		o.out_kind = k;
		o.out_seq = s;
		o.out_tag = t;
		o.out_length = l;
		o.send_ack = a;
		o.header_word = h;
		o.last = lst;
		return o;
	endfunction

	logic rel_in;
	logic [15:0] ack_hdr;
	assign rel_in = (r_q.pkt_type == srb_pkg::PT_REL);
	assign ack_hdr = rel_in ? {srb_pkg::PT_ACK, r_q.pkt_seq} : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			send_q <= '0;
			exp_q <= '0;
			out_v_q <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			dup_q <= 1'b0;
			pop_mode_q <= 1'b0;
			after_q <= 1'b0;
			nfree_q <= '0;
		end else begin
			if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q <= req.payload;
						nfree_q <= '0;
						unique case (req.payload.operation)
							srb_pkg::OP_ARRIVE: begin
								if (req.payload.frame_len < 11'd2) begin
									out_q <= mk(srb_pkg::K_SHORT, req.payload.pkt_seq,
										req.payload.buf_tag, '0, 1'b0, '0, 1'b1);
									out_v_q <= 1'b1;
								end else if (req.payload.pkt_type == srb_pkg::PT_ACK) begin
									out_q <= mk((req.payload.pkt_seq == send_q) ?
										srb_pkg::K_ACK_OK : srb_pkg::K_STRAY,
										req.payload.pkt_seq, '0, '0, 1'b0, '0, 1'b1);
									out_v_q <= 1'b1;
								end else begin
									idx_q <= cnt_q;
									found_q <= 1'b0;
									pos_q <= '0;
									st_q <= S_RD;
								end
							end
							srb_pkg::OP_TX: begin
								out_q <= mk(srb_pkg::K_TX, send_q + 1'b1, '0, '0, 1'b0,
									{(req.payload.pkt_type == srb_pkg::PT_REL) ?
									srb_pkg::PT_REL : srb_pkg::PT_UNREL,
									SW'(send_q + 1'b1)}, 1'b1);
								send_q <= send_q + 1'b1;
								out_v_q <= 1'b1;
							end
							srb_pkg::OP_DELIVER: begin
								idx_q <= '0;
								st_q <= S_HEAD;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (srb_pkg::seq_dist(r_q.pkt_seq, exp_q) <= 0) begin
						out_q <= mk(srb_pkg::K_STALE, r_q.pkt_seq, r_q.buf_tag, '0,
							rel_in, ack_hdr, 1'b1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (idx_q == '0) begin
						st_q <= S_DECI;
					end else begin
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (d_new >= 0) begin
						pos_q <= idx_q;
						dup_q <= (rd_q.seq == r_q.pkt_seq);
						found_q <= 1'b1;
						st_q <= S_DECI;
					end else begin
						idx_q <= idx_q - 1'b1;
						st_q <= (idx_q == CW'(1)) ? S_DECI : S_RD;
					end
				end
				S_DECI: begin
					if (found_q && dup_q) begin
						out_q <= mk(srb_pkg::K_DUP, r_q.pkt_seq, r_q.buf_tag, '0,
							rel_in, ack_hdr, 1'b1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (cnt_q >= DEPTH_C) begin
						out_q <= mk(srb_pkg::K_FULL, r_q.pkt_seq, r_q.buf_tag, '0,
							rel_in, ack_hdr, 1'b1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						hold_q <= '{seq: r_q.pkt_seq, rel: rel_in,
							len: r_q.frame_len - 11'd2, tag: r_q.buf_tag};
						pop_mode_q <= 1'b0;
						idx_q <= cnt_q;
						st_q <= (cnt_q == pos_q) ? S_SHWR : S_SHRD;
					end
				end
				S_SHRD: st_q <= S_SHWR;
				S_SHWR: begin
					if (pop_mode_q) begin
						if (idx_q == cnt_q) begin
							cnt_q <= cnt_q - 1'b1;
							st_q <= after_q ? S_IDLE : S_HEAD;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q <= S_POP;
						end
					end else if (idx_q == pos_q) begin
						cnt_q <= cnt_q + 1'b1;
						out_q <= mk(srb_pkg::K_QUEUED, r_q.pkt_seq, r_q.buf_tag, '0,
							rel_in, ack_hdr, 1'b1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q - 1'b1;
						st_q <= (idx_q - 1'b1 == pos_q) ? S_SHWR : S_SHRD;
					end
				end
				S_POP: st_q <= S_SHWR;
				S_HEAD: begin
					if (out_v_q) begin
						st_q <= S_HEAD;
					end else if (idx_q >= cnt_q) begin
						out_q <= mk(srb_pkg::K_NONE, exp_q, '0, '0, 1'b0, '0, 1'b1);
						out_v_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						st_q <= S_HEADC;
					end
				end
				S_HEADC: begin
					if (idx_q == '0 && d_head <= 0 && nfree_q < DEPTH_C) begin
						out_q <= mk(srb_pkg::K_FREED, rd_q.seq, rd_q.tag, '0, 1'b0, '0, 1'b0);
						out_v_q <= 1'b1;
						nfree_q <= nfree_q + 1'b1;
						pop_mode_q <= 1'b1;
						after_q <= 1'b0;
						idx_q <= CW'(1);
						st_q <= (cnt_q == CW'(1)) ? S_SHWR : S_POP;
					end else if (idx_q == '0 && d_head == 1) begin
						out_q <= mk(srb_pkg::K_DELIVERED, rd_q.seq, rd_q.tag, clip, 1'b0,
							'0, 1'b1);
						out_v_q <= 1'b1;
						exp_q <= exp_q + 1'b1;
						pop_mode_q <= 1'b1;
						after_q <= 1'b1;
						idx_q <= CW'(1);
						st_q <= (cnt_q == CW'(1)) ? S_SHWR : S_POP;
					end else if (rd_q.rel || d_head >= signed'({1'b0, win_q})) begin
						out_q <= mk(srb_pkg::K_GAP, exp_q + 1'b1, '0, '0, 1'b0, '0, 1'b1);
						out_v_q <= 1'b1;
						exp_q <= exp_q + 1'b1;
						st_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_OUT;
					end
				end
				S_OUT: st_q <= S_HEAD;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/sequence_reorder_buffer_unit_test.sv
`timescale 1ns / 1ps
module sequence_reorder_buffer_unit_test;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] PT_TRAV = 2'd3;
	localparam int DEPTH = 16;
	localparam int SETTLE = 300;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	srb_req_if req ();
	srb_rsp_if rsp ();

	sequence_reorder_buffer_unit i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	srb_pkg::req_t packets_to_send[$];
	srb_pkg::rsp_t due_results[$];
	int error_count = 0;
	bit req_taken = 0;
	int burst_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	int cycle_count = 0;

	logic [srb_pkg::SEQ_W-1:0] q_seq [DEPTH];
	logic [1:0] q_kind [DEPTH];
	logic [srb_pkg::LEN_W-1:0] q_len [DEPTH];
	logic [srb_pkg::TAG_W-1:0] q_tag [DEPTH];
	int q_count = 0;
	logic [srb_pkg::SEQ_W-1:0] tx_seq = '0;
	logic [srb_pkg::SEQ_W-1:0] next_expected = '0;
	logic [srb_pkg::WIN_W-1:0] window = 13'd3;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int serial_gap(logic [srb_pkg::SEQ_W-1:0] a,
		logic [srb_pkg::SEQ_W-1:0] b);
		logic [srb_pkg::SEQ_W-1:0] d;
		d = a - b;
		return d[srb_pkg::SEQ_W-1] ? int'(d) - 16384 : int'(d);
	endfunction

	function automatic void add_result(logic [3:0] kind, logic [srb_pkg::SEQ_W-1:0] seq,
		logic [srb_pkg::TAG_W-1:0] tag, logic [srb_pkg::LEN_W-1:0] len, logic ack,
		logic [15:0] hdr);
		srb_pkg::rsp_t r;
		r.out_kind = kind;
		r.out_seq = seq;
		r.out_tag = tag;
		r.out_length = len;
		r.send_ack = ack;
		r.header_word = hdr;
		r.last = 1'b0;
		due_results.push_back(r);
	endfunction

	function automatic void drop_head();
		for (int i = 1; i < q_count; i++) begin
			q_seq[i-1] = q_seq[i];
			q_kind[i-1] = q_kind[i];
			q_len[i-1] = q_len[i];
			q_tag[i-1] = q_tag[i];
		end
		if (q_count > 0) q_count--;
	endfunction

	function automatic void handle_arrival(srb_pkg::req_t p);
		logic ack;
		logic [15:0] hdr;
		int pos;
		ack = 1'b0;
		hdr = '0;
		pos = 0;
		if (p.frame_len < 2) begin
			add_result(srb_pkg::K_SHORT, p.pkt_seq, p.buf_tag, '0, 1'b0, '0);
			return;
		end
		if (p.pkt_type == srb_pkg::PT_ACK) begin
			add_result(p.pkt_seq == tx_seq ? srb_pkg::K_ACK_OK : srb_pkg::K_STRAY,
				p.pkt_seq, '0, '0, 1'b0, '0);
			return;
		end
		if (p.pkt_type == srb_pkg::PT_REL) begin
			ack = 1'b1;
			hdr = {srb_pkg::PT_ACK, p.pkt_seq};
		end
		if (serial_gap(p.pkt_seq, next_expected) <= 0) begin
			add_result(srb_pkg::K_STALE, p.pkt_seq, p.buf_tag, '0, ack, hdr);
			return;
		end
		for (int i = q_count; i > 0; i--) begin
			if (serial_gap(p.pkt_seq, q_seq[i-1]) >= 0) begin
				pos = i;
				break;
			end
		end
		if (pos > 0 && q_seq[pos-1] == p.pkt_seq) begin
			add_result(srb_pkg::K_DUP, p.pkt_seq, p.buf_tag, '0, ack, hdr);
			return;
		end
		if (q_count >= DEPTH) begin
			add_result(srb_pkg::K_FULL, p.pkt_seq, p.buf_tag, '0, ack, hdr);
			return;
		end
		for (int i = q_count; i > pos; i--) begin
			q_seq[i] = q_seq[i-1];
			q_kind[i] = q_kind[i-1];
			q_len[i] = q_len[i-1];
			q_tag[i] = q_tag[i-1];
		end
		q_seq[pos] = p.pkt_seq;
		q_kind[pos] = (p.pkt_type == srb_pkg::PT_REL) ? srb_pkg::PT_REL : srb_pkg::PT_UNREL;
		q_len[pos] = p.frame_len - 11'd2;
		q_tag[pos] = p.buf_tag;
		q_count++;
		add_result(srb_pkg::K_QUEUED, p.pkt_seq, p.buf_tag, '0, ack, hdr);
	endfunction

	function automatic void handle_delivery(srb_pkg::req_t p);
		int n;
		n = 0;
		while (q_count > 0 && n < DEPTH && serial_gap(q_seq[0], next_expected) <= 0) begin
			add_result(srb_pkg::K_FREED, q_seq[0], q_tag[0], '0, 1'b0, '0);
			n++;
			drop_head();
		end
		if (q_count > 0 && serial_gap(q_seq[0], next_expected) == 1) begin
			add_result(srb_pkg::K_DELIVERED, q_seq[0], q_tag[0],
				q_len[0] > p.capacity ? p.capacity : q_len[0], 1'b0, '0);
			drop_head();
			next_expected++;
			return;
		end
		for (int i = 0; i < q_count; i++) begin
			if (q_kind[i] == srb_pkg::PT_REL ||
				serial_gap(q_seq[i], next_expected) >= int'(window)) begin
				next_expected++;
				add_result(srb_pkg::K_GAP, next_expected, '0, '0, 1'b0, '0);
				return;
			end
		end
		add_result(srb_pkg::K_NONE, next_expected, '0, '0, 1'b0, '0);
	endfunction

	function automatic void forecast_results(srb_pkg::req_t p);
		int prior_count;
		prior_count = due_results.size();
		case (p.operation)
			srb_pkg::OP_ARRIVE: handle_arrival(p);
			srb_pkg::OP_TX: begin
				tx_seq++;
				add_result(srb_pkg::K_TX, tx_seq, '0, '0, 1'b0,
					{(p.pkt_type == srb_pkg::PT_REL) ? srb_pkg::PT_REL : srb_pkg::PT_UNREL,
					tx_seq});
			end
			srb_pkg::OP_DELIVER: handle_delivery(p);
			default: ;
		endcase
		if (due_results.size() > prior_count) due_results[due_results.size()-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		srb_pkg::rsp_t want;
		srb_pkg::rsp_t got;
		if (req.valid && req.ready) begin
			forecast_results(req.payload);
			req_taken = 1;
		end
		if (rsp.valid && rsp.ready) begin
			got = rsp.payload;
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result, kind", got.out_kind, -1);
			end else begin
				want = due_results.pop_front();
				if (got.out_kind !== want.out_kind)
					report_mismatch("out_kind", got.out_kind, want.out_kind);
				if (got.out_seq !== want.out_seq)
					report_mismatch("out_seq", got.out_seq, want.out_seq);
				if (got.out_tag !== want.out_tag)
					report_mismatch("out_tag", got.out_tag, want.out_tag);
				if (got.out_length !== want.out_length)
					report_mismatch("out_length", got.out_length, want.out_length);
				if (got.send_ack !== want.send_ack)
					report_mismatch("send_ack", got.send_ack, want.send_ack);
				if (got.header_word !== want.header_word)
					report_mismatch("header_word", got.header_word, want.header_word);
				if (got.last !== want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
		cycle_count++;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
			(packets_to_send.size() == 0 && !req.valid && due_results.size() == 0)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		logic next_valid;
		srb_pkg::req_t next_item;
		next_valid = req.valid && !req_taken;
		next_item = req.payload;
		req_taken = 0;
		if (!next_valid && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (packets_to_send.size() > 0) begin
				next_item = packets_to_send.pop_front();
				next_valid = 1'b1;
				if (burst_left == 0) burst_left = $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			end
		end
		req.valid <= next_valid;
		req.payload <= next_item;
	end

	always @(negedge clk) begin
		case ((cycle_count / 700) % 3)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 9) < 7);
			default: rsp.ready <= ((cycle_count % 16) < 5);
		endcase
	end

	function automatic srb_pkg::req_t make_item(logic [1:0] op, logic [1:0] kind,
		logic [srb_pkg::SEQ_W-1:0] seq, logic [srb_pkg::LEN_W-1:0] flen,
		logic [srb_pkg::TAG_W-1:0] tag, logic [srb_pkg::LEN_W-1:0] cap);
		srb_pkg::req_t p;
		p.operation = op;
		p.pkt_type = kind;
		p.pkt_seq = seq;
		p.frame_len = flen;
		p.buf_tag = tag;
		p.capacity = cap;
		return p;
	endfunction

	function automatic logic [srb_pkg::LEN_W-1:0] pick_len();
		return 11'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 2047) :
			$urandom_range(2, 64));
	endfunction

	task automatic wait_idle();
		while (packets_to_send.size() > 0 || req.valid || due_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(logic [srb_pkg::WIN_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= srb_pkg::REG_WINDOW;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		window = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic fill_random(int total);
		logic [srb_pkg::SEQ_W-1:0] base;
		int made;
		int k;
		int skip;
		int offs [8];
		int j;
		int t;
		logic [1:0] kind;
		base = next_expected;
		made = 0;
		while (made < total) begin
			t = $urandom_range(0, 99);
			if (t < 15) begin
				packets_to_send.push_back(make_item(2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)),
					11'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535)),
					11'($urandom_range(0, 2047))));
				if (packets_to_send[$].operation != OP_UNUSED) made++;
			end else if (t < 22) begin
				packets_to_send.push_back(make_item(srb_pkg::OP_TX, 2'($urandom_range(0, 3)),
					'0, '0, '0, '0));
				made++;
			end else begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++) offs[i] = i + 1;
				for (int i = k - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = offs[i];
					offs[i] = offs[j];
					offs[j] = t;
				end
				skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k - 1) : -1;
				for (int i = 0; i < k; i++) begin
					if (i == skip) continue;
					t = $urandom_range(0, 9);
					kind = (t < 6) ? srb_pkg::PT_UNREL : (t < 9) ? srb_pkg::PT_REL : PT_TRAV;
					packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, kind,
						14'(base + offs[i]), pick_len(), 16'($urandom_range(0, 65535)), '0));
					made++;
				end
				for (int i = 0; i <= k; i++) begin
					packets_to_send.push_back(make_item(srb_pkg::OP_DELIVER, '0, '0, '0, '0,
						11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) :
						$urandom_range(0, 80))));
					made++;
				end
				base = base + 14'(k);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_REL, 14'd5, 11'd0,
			16'hFFFF, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_UNREL, 14'd6,
			11'd1, 16'h1234, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_ACK, 14'd0, 11'd2,
			16'h5555, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_ACK, 14'h3FFF,
			11'd9, 16'hAAAA, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_TX, srb_pkg::PT_REL, '0, '0, '0, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_TX, PT_TRAV, '0, '0, '0, '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_REL, 14'd0,
			11'd2047, 16'hFFFF, '0));
		for (int i = 0; i < 17; i++)
			packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE,
				(i % 3 == 0) ? PT_TRAV : srb_pkg::PT_UNREL,
				14'(i + 2), 11'd2047 - 11'(i), 16'(i * 4111), '0));
		packets_to_send.push_back(make_item(srb_pkg::OP_DELIVER, '0, '0, '0, '0, 11'd2047));
		packets_to_send.push_back(make_item(srb_pkg::OP_DELIVER, '0, '0, '0, '0, 11'd0));
		packets_to_send.push_back(make_item(srb_pkg::OP_ARRIVE, srb_pkg::PT_REL, 14'd3, 11'd20,
			16'h0F0F, '0));
		packets_to_send.push_back(make_item(OP_UNUSED, srb_pkg::PT_REL, 14'h3FFF, 11'd2047,
			16'hFFFF, 11'd2047));
		wait_idle();

		write_window(13'd0);
		fill_random(60);
		wait_idle();
		write_window(13'd8191);
		fill_random(50);
		wait_idle();
		write_window(13'd3);
		fill_random(70);
		wait_idle();
		write_window(13'($urandom_range(1, 8190)));
		fill_random(50);
		wait_idle();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
